FILE: rtl/core/tns_pkg.sv
`timescale 1ns / 1ps
// Package for the type name splitter.
// Holds the shared state types, command and status structs, character
// constants and character classes. Depends on nothing.
package tns_pkg;

    // Default buffer length for one word.
    localparam int NAME_LEN_DEF = 16;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // Scanner states.
    typedef enum logic [2:0] {
        SCAN_WAIT      = 3'd0,
        SCAN_WORD      = 3'd1,
        SCAN_COLON2    = 3'd2,
        SCAN_WAIT_TYPE = 3'd3,
        SCAN_TYPE      = 3'd4,
        SCAN_ABORT     = 3'd5
    } tns_scan_t;

    // Controller states.
    typedef enum logic [1:0] {
        CTL_SCAN,
        CTL_READ,
        CTL_SHOW
    } tns_ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic read;
        logic advance;
    } tns_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pair_close;
        logic emit_last;
    } tns_status_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_STAR || c == CH_AMP;
    endfunction

    function automatic logic is_closer(input logic [7:0] c);
        return c == CH_LT || c == CH_COMMA || c == CH_GT;
    endfunction

endpackage

FILE: rtl/core/type_name_splitter.sv
`timescale 1ns / 1ps
// Top level of the type name splitter.
// Joins the controller tns_ctrl and the datapath tns_dp; uses tns_pkg.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_ready    | char_code, end_of_name
//  output   | out_valid / out_ready  | out_char, is_type_char, pair_last, truncated
//
// A character that closes no pair leaves the input ready for the next one.
// After a closing character each emitted character is read from the word
// memory, then offered from the output register: one memory port serves emission.
// Input is not taken while a pair is being emitted; a stalled output holds.
// After reset the scanner waits for a letter; the word memory needs no clearing.
module type_name_splitter #(
    parameter int NAME_LEN = tns_pkg::NAME_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_name,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       is_type_char,
    output logic       pair_last,
    output logic       truncated
);
    import tns_pkg::*;

    tns_cmd_t    cmd;
    tns_status_t status;

    // Sequencing of scan and emission.
    tns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Scanner, word memory and output register.
    tns_dp #(
        .NAME_LEN (NAME_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .char_code    (char_code),
        .end_of_name  (end_of_name),
        .out_char     (out_char),
        .is_type_char (is_type_char),
        .pair_last    (pair_last),
        .truncated    (truncated)
    );

endmodule

FILE: rtl/core/tns_ctrl.sv
`timescale 1ns / 1ps
// Controller for the type name splitter.
// Sequences scanning and the emission of one pair; uses tns_pkg.
module tns_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tns_pkg::tns_status_t  status,
    output tns_pkg::tns_cmd_t     cmd
);
    import tns_pkg::*;

    tns_ctl_state_t state_reg;
    tns_ctl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_SCAN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and outputs.
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.accept  = 1'b0;
        cmd.read    = 1'b0;
        cmd.advance = 1'b0;
        unique case (state_reg)
            CTL_SCAN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.pair_close)
                    begin
                        state_next = CTL_READ;
                    end
                end
            end
            CTL_READ:
            begin
                cmd.read   = 1'b1;
                state_next = CTL_SHOW;
            end
            CTL_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    state_next  = status.emit_last ? CTL_SCAN : CTL_READ;
                end
            end
            default:
            begin
                state_next = CTL_SCAN;
            end
        endcase
    end

`ifndef SYNTH
    // Input is never taken while a character is on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken during emission");

    // The last character of a pair returns control to scanning.
    a_back_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.emit_last) |=> in_ready)
        else $error("scanner not resumed after pair");

    // A closing input item always starts a read.
    a_close_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.pair_close) |=> cmd.read)
        else $error("pair close did not start emission");
`endif

endmodule

FILE: rtl/core/tns_dp.sv
`timescale 1ns / 1ps
// Datapath for the type name splitter.
// Holds the scanner state, the two-bank word memory and the output register;
// uses tns_pkg.
module tns_dp #(
    parameter int NAME_LEN = tns_pkg::NAME_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tns_pkg::tns_cmd_t     cmd,
    output tns_pkg::tns_status_t  status,
    input  logic [7:0]            char_code,
    input  logic                  end_of_name,
    output logic [7:0]            out_char,
    output logic                  is_type_char,
    output logic                  pair_last,
    output logic                  truncated
);
    import tns_pkg::*;

    localparam int IW    = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
    localparam int LW    = $clog2(NAME_LEN + 1);
    localparam int CW    = $clog2(2 * NAME_LEN + 1);
    localparam int DEPTH = 2 << IW;

    // Word memory: the bank bit picks which half holds the current word.
    logic [7:0] mem [DEPTH];

    tns_scan_t   scan_reg;
    logic [LW-1:0] word_len_reg;
    logic [LW-1:0] scope_len_reg;
    logic        word_ovf_reg;
    logic        scope_ovf_reg;
    logic        bank_reg;

    // Snapshot of the pair being emitted.
    logic [LW-1:0] p_slen_reg;
    logic [LW-1:0] p_wlen_reg;
    logic        p_trunc_reg;
    logic        p_bank_reg;
    logic [CW-1:0] idx_reg;

    logic [7:0]  out_char_reg;
    logic        type_reg;
    logic        last_reg;

    // Scanner next values.
    tns_scan_t   scan_next;
    logic [LW-1:0] word_len_next;
    logic [LW-1:0] scope_len_next;
    logic        word_ovf_next;
    logic        scope_ovf_next;
    logic        bank_next;
    logic        append;
    logic        room;
    logic        close;
    logic        emit;

    // Emission address and flags.
    logic [CW-1:0] total;
    logic [CW-1:0] offset;
    logic        in_scope;
    logic [IW:0] rd_addr;

    // One character of scanning, following the scanner states of tns_pkg.
    always_comb
    begin
        scan_next      = scan_reg;
        word_len_next  = word_len_reg;
        scope_len_next = scope_len_reg;
        word_ovf_next  = word_ovf_reg;
        scope_ovf_next = scope_ovf_reg;
        bank_next      = bank_reg;
        append         = 1'b0;
        close          = 1'b0;
        unique case (scan_reg)
            SCAN_WAIT:
            begin
                if (is_letter(char_code))
                begin
                    append    = 1'b1;
                    scan_next = SCAN_WORD;
                end
            end
            SCAN_WORD:
            begin
                if (is_word_char(char_code))
                begin
                    append = 1'b1;
                end
                else if (char_code == CH_COLON)
                begin
                    scope_len_next = word_len_reg;
                    scope_ovf_next = word_ovf_reg;
                    word_len_next  = '0;
                    word_ovf_next  = 1'b0;
                    bank_next      = ~bank_reg;
                    scan_next      = SCAN_COLON2;
                end
                else if (is_closer(char_code))
                begin
                    close     = 1'b1;
                    scan_next = SCAN_WAIT;
                end
            end
            SCAN_COLON2:
            begin
                scan_next = (char_code == CH_COLON) ? SCAN_WAIT_TYPE : SCAN_ABORT;
            end
            SCAN_WAIT_TYPE:
            begin
                if (is_letter(char_code))
                begin
                    append    = 1'b1;
                    scan_next = SCAN_TYPE;
                end
            end
            SCAN_TYPE:
            begin
                if (is_word_char(char_code))
                begin
                    append = 1'b1;
                end
                else if (is_closer(char_code))
                begin
                    close     = 1'b1;
                    scan_next = SCAN_WAIT;
                end
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
        room = word_len_reg < LW'(NAME_LEN);
        if (append)
        begin
            if (room)
            begin
                word_len_next = word_len_reg + 1'b1;
            end
            else
            begin
                word_ovf_next = 1'b1;
            end
        end
        emit = close || (end_of_name &&
               (scan_next == SCAN_WORD || scan_next == SCAN_TYPE));
    end

    // Read address: scope characters first, then the type word.
    always_comb
    begin
        total    = CW'(p_slen_reg) + CW'(p_wlen_reg);
        in_scope = idx_reg < CW'(p_slen_reg);
        offset   = idx_reg - CW'(p_slen_reg);
        if (in_scope)
        begin
            rd_addr = {~p_bank_reg, idx_reg[IW-1:0]};
        end
        else
        begin
            rd_addr = {p_bank_reg, offset[IW-1:0]};
        end
    end

    // Scanner and pair control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= SCAN_WAIT;
            word_len_reg  <= '0;
            scope_len_reg <= '0;
            word_ovf_reg  <= 1'b0;
            scope_ovf_reg <= 1'b0;
            bank_reg      <= 1'b0;
            idx_reg       <= '0;
            p_slen_reg    <= '0;
            p_wlen_reg    <= '0;
            p_trunc_reg   <= 1'b0;
            p_bank_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                scan_reg  <= end_of_name ? SCAN_WAIT : scan_next;
                bank_reg  <= bank_next;
                if (emit || end_of_name)
                begin
                    word_len_reg  <= '0;
                    scope_len_reg <= '0;
                    word_ovf_reg  <= 1'b0;
                    scope_ovf_reg <= 1'b0;
                end
                else
                begin
                    word_len_reg  <= word_len_next;
                    scope_len_reg <= scope_len_next;
                    word_ovf_reg  <= word_ovf_next;
                    scope_ovf_reg <= scope_ovf_next;
                end
                if (emit)
                begin
                    idx_reg     <= '0;
                    p_slen_reg  <= scope_len_next;
                    p_wlen_reg  <= word_len_next;
                    p_trunc_reg <= scope_ovf_next | word_ovf_next;
                    p_bank_reg  <= bank_next;
                end
            end
            if (cmd.advance)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Word memory write and registered read into the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && append && room)
        begin
            mem[{bank_reg, word_len_reg[IW-1:0]}] <= char_code;
        end
        if (cmd.read)
        begin
            out_char_reg <= mem[rd_addr];
            type_reg     <= ~in_scope;
            last_reg     <= (idx_reg + 1'b1) == total;
        end
    end

    assign out_char          = out_char_reg;
    assign is_type_char      = type_reg;
    assign pair_last         = last_reg;
    assign truncated         = p_trunc_reg;
    assign status.pair_close = emit;
    assign status.emit_last  = last_reg;

`ifndef SYNTH
    // Word lengths never pass the buffer size.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        word_len_reg <= LW'(NAME_LEN) && scope_len_reg <= LW'(NAME_LEN))
        else $error("word length beyond buffer");

    // A read only happens inside the pair being emitted.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> idx_reg < total)
        else $error("read beyond pair");

    // An emitted pair always carries a type word.
    a_type_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && emit) |=> p_wlen_reg != '0)
        else $error("empty type word in pair");
`endif

endmodule

FILE: test/tb_type_name_splitter.sv
`timescale 1ns / 1ps
// Self-checking testbench for type_name_splitter: feeds type names one character per item
// and checks every emitted scope and type character against an internal scanner model.
// Depends on tns_pkg and the RTL of type_name_splitter only.
module tb_type_name_splitter;

    import tns_pkg::*;

    localparam int WORD_MAX       = tns_pkg::NAME_LEN_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LIVE_TARGET    = 500;
    localparam int MAX_REPORTS    = 10;

    // Characters that steer the scanner.
    localparam logic [7:0] COLON       = ":";
    localparam logic [7:0] ANGLE_OPEN  = "<";
    localparam logic [7:0] ANGLE_CLOSE = ">";
    localparam logic [7:0] COMMA       = ",";
    localparam logic [7:0] STAR        = "*";
    localparam logic [7:0] AMP         = "&";

    // One emitted character as the block presents it.
    typedef struct packed {
        logic [7:0] ch;
        logic       type_char;
        logic       last;
        logic       trunc;
    } split_char_t;

    // Scanner model plus the queue of characters it expects the block to emit.
    class split_scoreboard;
        tns_scan_t   scan;
        logic [7:0]  word_chars[WORD_MAX];
        logic [7:0]  scope_chars[WORD_MAX];
        int          word_len;
        int          scope_len;
        bit          word_ovf;
        bit          scope_ovf;
        split_char_t expected_chars[$];
        int          chars_in;
        int          live_chars;
        int          mismatches;

        function new();
            chars_in   = 0;
            live_chars = 0;
            mismatches = 0;
            clear_name();
        endfunction

        function void clear_name();
            scan      = SCAN_WAIT;
            word_len  = 0;
            scope_len = 0;
            word_ovf  = 1'b0;
            scope_ovf = 1'b0;
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit ident_char(logic [7:0] c);
            return alpha(c) || (c >= "0" && c <= "9") || c == STAR || c == AMP;
        endfunction

        function bit pair_end(logic [7:0] c);
            return c == ANGLE_OPEN || c == COMMA || c == ANGLE_CLOSE;
        endfunction

        // Characters past the buffer are dropped and mark the word as cut.
        function void add_char(logic [7:0] c);
            if (word_len < WORD_MAX)
            begin
                word_chars[word_len] = c;
                word_len++;
            end
            else
            begin
                word_ovf = 1'b1;
            end
        endfunction

        // Queue the scope characters, then the type characters, and empty both words.
        function void emit_pair();
            int          total;
            int          n;
            split_char_t r;
            total   = scope_len + word_len;
            n       = 0;
            r.trunc = scope_ovf | word_ovf;
            for (int i = 0; i < scope_len; i++)
            begin
                r.ch        = scope_chars[i];
                r.type_char = 1'b0;
                r.last      = (n + 1 == total);
                expected_chars.insert(expected_chars.size(), r);
                n++;
            end
            for (int i = 0; i < word_len; i++)
            begin
                r.ch        = word_chars[i];
                r.type_char = 1'b1;
                r.last      = (n + 1 == total);
                expected_chars.insert(expected_chars.size(), r);
                n++;
            end
            word_len  = 0;
            scope_len = 0;
            word_ovf  = 1'b0;
            scope_ovf = 1'b0;
        endfunction

        // Advance the scanner by one accepted input item.
        function void note_char(logic [7:0] c, logic name_end);
            chars_in++;
            if (scan != SCAN_ABORT)
                live_chars++;
            case (scan)
                SCAN_WAIT:
                begin
                    if (alpha(c))
                    begin
                        add_char(c);
                        scan = SCAN_WORD;
                    end
                end
                SCAN_WORD:
                begin
                    if (ident_char(c))
                    begin
                        add_char(c);
                    end
                    else if (c == COLON)
                    begin
                        scope_chars = word_chars;
                        scope_len   = word_len;
                        scope_ovf   = word_ovf;
                        word_len    = 0;
                        word_ovf    = 1'b0;
                        scan        = SCAN_COLON2;
                    end
                    else if (pair_end(c))
                    begin
                        emit_pair();
                        scan = SCAN_WAIT;
                    end
                end
                SCAN_COLON2:
                begin
                    scan = (c == COLON) ? SCAN_WAIT_TYPE : SCAN_ABORT;
                end
                SCAN_WAIT_TYPE:
                begin
                    if (alpha(c))
                    begin
                        add_char(c);
                        scan = SCAN_TYPE;
                    end
                end
                SCAN_TYPE:
                begin
                    if (ident_char(c))
                    begin
                        add_char(c);
                    end
                    else if (pair_end(c))
                    begin
                        emit_pair();
                        scan = SCAN_WAIT;
                    end
                end
                default:
                begin
                end
            endcase
            // The end of the name flushes an open pair and restarts the scanner.
            if (name_end)
            begin
                if (scan == SCAN_WORD || scan == SCAN_TYPE)
                    emit_pair();
                clear_name();
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        // Compare one emitted character with the oldest expectation.
        function void check_char(split_char_t got);
            split_char_t want;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected character %h type %b last %b trunc %b",
                             got.ch, got.type_char, got.last, got.trunc);
                return;
            end
            want = expected_chars.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                             want.ch, want.type_char, want.last, want.trunc,
                             got.ch, got.type_char, got.last, got.trunc);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] char_code    = 8'h00;
    logic       end_of_name  = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] out_char;
    logic       is_type_char;
    logic       pair_last;
    logic       truncated;

    split_scoreboard names = new();
    logic [7:0]      name_buf[$];
    int              quiet_cycles = 0;
    bit              held_off     = 1'b0;

    type_name_splitter #(
        .NAME_LEN(WORD_MAX)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .end_of_name (end_of_name),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .is_type_char(is_type_char),
        .pair_last   (pair_last),
        .truncated   (truncated)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Every handshake on the output side goes to the scoreboard.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            names.check_char(split_char_t'({out_char, is_type_char, pair_last, truncated}));
    end

    // End the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL type_name_splitter");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, one long hold-off, and a window without stalls.
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (!held_off && names.chars_in >= 120)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            else if (names.chars_in >= 380 && names.chars_in < 480)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= 8);
            end
        end
    end

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "A" : "a";
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_ident();
        case ($urandom_range(0, 9))
            0: return STAR;
            1: return AMP;
            2, 3: return "0" + 8'($urandom_range(0, 9));
            default: return rand_letter();
        endcase
    endfunction

    function automatic logic [7:0] rand_closer();
        case ($urandom_range(0, 2))
            0: return ANGLE_OPEN;
            1: return COMMA;
            default: return ANGLE_CLOSE;
        endcase
    endfunction

    // Mostly short words; now and then one long enough to overflow the buffer.
    function automatic int word_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
    endfunction

    // Append one byte to the name under construction.
    function automatic void add_byte(logic [7:0] c);
        name_buf.insert(name_buf.size(), c);
    endfunction

    function automatic void push_word(int len);
        add_byte(rand_letter());
        for (int i = 1; i < len; i++)
            add_byte(rand_ident());
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_char(input logic [7:0] c, input logic name_end);
        bit quiet;
        quiet = (names.chars_in >= 250 && names.chars_in < 350);
        while (!quiet && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        char_code   <= c;
        end_of_name <= name_end;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        names.note_char(c, name_end);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // Build one random name: mostly well-formed pairs, some with a lone colon, some noise.
    task automatic send_random_name();
        int kind;
        int pairs;
        int broken_at;
        name_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 90)
        begin
            pairs     = $urandom_range(1, 4);
            broken_at = (kind >= 80) ? $urandom_range(0, pairs - 1) : -1;
            for (int p = 0; p < pairs; p++)
            begin
                if (p == broken_at)
                begin
                    push_word($urandom_range(1, 4));
                    add_byte(COLON);
                    add_byte(rand_letter());
                end
                if ($urandom_range(0, 1))
                begin
                    push_word(word_length());
                    add_byte(COLON);
                    add_byte(COLON);
                end
                push_word(word_length());
                if ($urandom_range(0, 9) == 0)
                    add_byte($urandom_range(0, 1) ? COLON : 8'($urandom_range(0, 255)));
                if (p < pairs - 1 || $urandom_range(0, 1))
                    add_byte(rand_closer());
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                add_byte(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < name_buf.size(); i++)
            send_char(name_buf[i], i == name_buf.size() - 1);
    endtask

    // Stimulus, drain and verdict.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scope with a colon inside the type, closed by a comma.
        send_text("q::Z9:*,");
        // Lone colon aborts the rest of the name.
        send_text("a:b");
        // Bytes at the extremes are skipped; the name ends inside a word.
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("z", 1'b1);
        // Name ends while waiting for the type after a scope.
        send_text("m::");
        // Both angle brackets close pairs.
        send_text("k<x>");
        // Name ends inside the type word.
        send_text("s::t");

        while (names.live_chars < LIVE_TARGET)
            send_random_name();
        in_valid <= 1'b0;

        while (names.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (names.mismatches == 0 && names.pending() == 0)
            $display("PASS type_name_splitter");
        else
            $display("FAIL type_name_splitter");
        $finish;
    end

endmodule

FILE: type_name_splitter.f
rtl/core/tns_pkg.sv
rtl/core/tns_ctrl.sv
rtl/core/tns_dp.sv
rtl/core/type_name_splitter.sv
test/tb_type_name_splitter.sv
